// ===== src/pmid_pkg.sv =====
// Shared widths and types for the periodic minimum-image distance block.
// No dependencies; every other file imports this package.
package pmid_pkg;

   localparam int COORD_W  = 24;              // input coordinate width
   localparam int BOX_W    = COORD_W - 1;     // box size and distance width
   localparam int MAG_W    = COORD_W + 1;     // magnitude of a coordinate difference
   localparam int REM_W    = BOX_W;           // remainder modulo box
   localparam int SQ_W     = 2 * MAG_W;       // one squared component
   localparam int SUM_W    = SQ_W + 2;        // sum of three squares
   localparam int ROOT_W   = SUM_W / 2;       // integer square root
   localparam int SREM_W   = ROOT_W + 2;      // square root partial remainder
   localparam int LANES    = 3;

   localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(4096);
   localparam logic [BOX_W-1:0] DIST_MAX  = {BOX_W{1'b1}};

   // One component moving through the remainder cells.
   typedef struct packed {
      logic [MAG_W-1:0] mag;   // untouched magnitude
      logic [MAG_W-1:0] shf;   // magnitude, next bit at the top
      logic [REM_W-1:0] rem;   // partial remainder
   } rem_lane_type;

   typedef rem_lane_type [LANES-1:0] rem_lanes_type;

   // Operand moving through the square root cells.
   typedef struct packed {
      logic [SREM_W-1:0] srem;
      logic [ROOT_W-1:0] root;
      logic [SUM_W-1:0]  sum;
   } sqrt_data_type;

endpackage

// ===== src/pmid_rem_cell.sv =====
// One bit of the restoring remainder (magnitude modulo box) for all three lanes.
// Depends on pmid_pkg.
module pmid_rem_cell import pmid_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [BOX_W-1:0] box,
   input  logic             valid_in,
   input  rem_lanes_type    lanes_in,
   output logic             valid_out,
   output rem_lanes_type    lanes_out
);

   logic          valid_ff;
   rem_lanes_type lanes_ff;
   rem_lanes_type lanes_nxt;

   always_comb begin
      logic [REM_W:0] t;
      t = '0;
      for (int k = 0; k < LANES; k++) begin
         lanes_nxt[k].mag = lanes_in[k].mag;
         lanes_nxt[k].shf = {lanes_in[k].shf[MAG_W-2:0], 1'b0};
         t = {lanes_in[k].rem, lanes_in[k].shf[MAG_W-1]};
         if (t >= {1'b0, box}) begin
            lanes_nxt[k].rem = REM_W'(t - {1'b0, box});
         end else begin
            lanes_nxt[k].rem = t[REM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lanes_ff <= lanes_nxt;
      end
   end

   assign valid_out = valid_ff;
   assign lanes_out = lanes_ff;

endmodule

// ===== src/pmid_sqrt_cell.sv =====
// One result bit of the digit-by-digit integer square root.
// Depends on pmid_pkg.
module pmid_sqrt_cell import pmid_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          valid_in,
   input  sqrt_data_type data_in,
   output logic          valid_out,
   output sqrt_data_type data_out
);

   logic          valid_ff;
   sqrt_data_type data_ff;
   sqrt_data_type data_nxt;

   always_comb begin
      logic [SREM_W+1:0] r2;
      logic [SREM_W+1:0] tr;
      r2 = {data_in.srem, data_in.sum[SUM_W-1 -: 2]};
      tr = {2'b00, data_in.root, 2'b01};
      data_nxt.sum = {data_in.sum[SUM_W-3:0], 2'b00};
      if (r2 >= tr) begin
         data_nxt.srem = SREM_W'(r2 - tr);
         data_nxt.root = {data_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_nxt.srem = r2[SREM_W-1:0];
         data_nxt.root = {data_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_nxt;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ===== src/periodic_min_image_distance.sv =====
// Throughput one pair per cycle while the output is not stalled. The pipe holds the 25 remainder
// cells and the 26 square root cells plus five registers for difference, wrap, square,
// sum and output; the whole pipe stalls together.
// Reset (synchronous, active high) empties the pipeline and sets box_size to 1.0 (4096).
// Top level; depends on pmid_pkg, pmid_rem_cell and pmid_sqrt_cell.
module periodic_min_image_distance import pmid_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [BOX_W-1:0]   csr_box_size,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_first_x,
   input  logic [COORD_W-1:0] req_first_y,
   input  logic [COORD_W-1:0] req_first_z,
   input  logic [COORD_W-1:0] req_second_x,
   input  logic [COORD_W-1:0] req_second_y,
   input  logic [COORD_W-1:0] req_second_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BOX_W-1:0]   rsp_wrapped_distance
);

   // The pipeline moves as one piece: it advances whenever the output register
   // is empty or its transaction is being taken this cycle.
   logic advance;
   logic out_valid_ff;
   logic [BOX_W-1:0] out_dist_ff;
   logic [BOX_W-1:0] box_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // The user must write configuration only while the pipe is empty (the block does not
   // enforce this), so every stage can read the register directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= BOX_RESET;
      end else if (csr_valid) begin
         box_ff <= csr_box_size;
      end
   end

   // Difference stage: magnitude of first minus second per axis.
   logic [COORD_W-1:0] first_c  [LANES];
   logic [COORD_W-1:0] second_c [LANES];
   logic [MAG_W-1:0]   mag_c    [LANES];
   logic               dif_valid_ff;
   rem_lanes_type      dif_lanes_ff;

   assign first_c[0]  = req_first_x;
   assign first_c[1]  = req_first_y;
   assign first_c[2]  = req_first_z;
   assign second_c[0] = req_second_x;
   assign second_c[1] = req_second_y;
   assign second_c[2] = req_second_z;

   always_comb begin
      logic [MAG_W-1:0] d;
      d = '0;
      for (int k = 0; k < LANES; k++) begin
         d = {first_c[k][COORD_W-1], first_c[k]} - {second_c[k][COORD_W-1], second_c[k]};
         mag_c[k] = d[MAG_W-1] ? MAG_W'(-d) : d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_valid_ff <= 1'b0;
      end else if (advance) begin
         dif_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < LANES; k++) begin
            dif_lanes_ff[k].mag <= mag_c[k];
            dif_lanes_ff[k].shf <= mag_c[k];
            dif_lanes_ff[k].rem <= '0;
         end
      end
   end

   // Remainder chain: one cell per magnitude bit, most significant first.
   logic          rem_valid [MAG_W+1];
   rem_lanes_type rem_lanes [MAG_W+1];

   assign rem_valid[0] = dif_valid_ff;
   assign rem_lanes[0] = dif_lanes_ff;

   for (genvar i = 0; i < MAG_W; i++) begin : g_rem
      pmid_rem_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .box       (box_ff),
         .valid_in  (rem_valid[i]),
         .lanes_in  (rem_lanes[i]),
         .valid_out (rem_valid[i+1]),
         .lanes_out (rem_lanes[i+1])
      );
   end

   // Wrap stage. With r the remainder, the nearest image is r when 2r is below
   // the box and box minus r otherwise; halves therefore come out as box/2.
   // A zero box disables wrapping.
   logic [MAG_W-1:0] wrap_c  [LANES];
   logic [MAG_W-1:0] wrap_ff [LANES];
   logic             wrap_valid_ff;

   always_comb begin
      logic [REM_W-1:0] r;
      r = '0;
      for (int k = 0; k < LANES; k++) begin
         r = rem_lanes[MAG_W][k].rem;
         if (box_ff == '0) begin
            wrap_c[k] = rem_lanes[MAG_W][k].mag;
         end else if ({r, 1'b0} >= {1'b0, box_ff}) begin
            wrap_c[k] = MAG_W'(box_ff - r);
         end else begin
            wrap_c[k] = MAG_W'(r);
         end
      end
   end

   // Square stage, then sum stage.
   logic [SQ_W-1:0]  sq_ff [LANES];
   logic             sq_valid_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             sum_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
         sq_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else if (advance) begin
         wrap_valid_ff <= rem_valid[MAG_W];
         sq_valid_ff   <= wrap_valid_ff;
         sum_valid_ff  <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < LANES; k++) begin
            wrap_ff[k] <= wrap_c[k];
            sq_ff[k]   <= wrap_ff[k] * wrap_ff[k];
         end
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      end
   end

   // Square root chain: one cell per root bit.
   logic          sqr_valid [ROOT_W+1];
   sqrt_data_type sqr_data  [ROOT_W+1];

   assign sqr_valid[0]     = sum_valid_ff;
   assign sqr_data[0].srem = '0;
   assign sqr_data[0].root = '0;
   assign sqr_data[0].sum  = sum_ff;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      pmid_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (sqr_valid[j]),
         .data_in   (sqr_data[j]),
         .valid_out (sqr_valid[j+1]),
         .data_out  (sqr_data[j+1])
      );
   end

   // Output register with saturation of distances beyond the field's range.
   logic [ROOT_W-1:0] root_c;
   assign root_c = sqr_data[ROOT_W].root;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= sqr_valid[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (root_c > ROOT_W'(DIST_MAX)) begin
            out_dist_ff <= DIST_MAX;
         end else begin
            out_dist_ff <= root_c[BOX_W-1:0];
         end
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_wrapped_distance = out_dist_ff;

endmodule

// ===== src/pmid_checker.sv =====
// Port-level checks for periodic_min_image_distance, bound to the top level.
// Depends on pmid_pkg.
module pmid_checker import pmid_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [BOX_W-1:0] rsp_wrapped_distance
);

   // The pipe is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Requests are taken exactly when the pipe can move.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response backpressure");

   // A stalled response holds its distance.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wrapped_distance))
      else $error("stalled response changed");

   // A stalled response also stalls the request side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

endmodule

bind periodic_min_image_distance pmid_checker u_pmid_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_wrapped_distance (rsp_wrapped_distance)
);
